// ----- hdl/fpalu_pkg.sv -----
package fpalu_pkg;

   localparam int FRAC_BITS = 8;
   localparam int WIDTH = 32;
   localparam int PORT_BITS = 32;
   localparam int QUO_BITS = WIDTH + FRAC_BITS;
   localparam int LATENCY = QUO_BITS + 2;

   typedef enum logic [2:0] {
      OP_ADD = 3'd0,
      OP_SUB = 3'd1,
      OP_MUL = 3'd2,
      OP_DIV = 3'd3,
      OP_MIN = 3'd4,
      OP_MAX = 3'd5,
      OP_RSV6 = 3'd6,
      OP_RSV7 = 3'd7
   } op_type;

   typedef struct packed {
      logic                valid;
      op_type              op;
      logic [WIDTH-1:0]    result;
      logic                zero_div;
      logic                lt;
      logic                eq;
      logic                gt;
      logic                neg;
      logic [WIDTH-1:0]    rem;
      logic [QUO_BITS-1:0] dq;
      logic [WIDTH-1:0]    dsr;
   } stage_type;

endpackage

// ----- hdl/fixed_point_alu_q24_8.sv -----
// Channel   | Handshake          | Words
// request   | start, busy        | req_type, req_operand_a, req_operand_b
// response  | rsp_valid (strobe) | rsp_result_raw, rsp_div_by_zero, rsp_a_less,
//           |                    | rsp_a_equal, rsp_a_greater
//
// A word is accepted in every cycle in which busy is low. The pipeline depth is set by
// the divider, which resolves one quotient bit per stage over WIDTH + FRAC_BITS stages,
// with one stage before and one after it.
// Every operation travels the same pipeline, so responses keep request order.
// Reset is synchronous and empties the pipeline; busy is high only during reset.
// The receiver cannot stall, so the pipeline never halts.
module fixed_point_alu_q24_8
   import fpalu_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [2:0]                  req_type,
   input  logic signed [PORT_BITS-1:0] req_operand_a,
   input  logic signed [PORT_BITS-1:0] req_operand_b,
   output logic                        rsp_valid,
   output logic signed [PORT_BITS-1:0] rsp_result_raw,
   output logic                        rsp_div_by_zero,
   output logic                        rsp_a_less,
   output logic                        rsp_a_equal,
   output logic                        rsp_a_greater
);

   stage_type pipe_ff [0:QUO_BITS];
   stage_type pipe_in [0:QUO_BITS];

   logic signed [WIDTH-1:0]   a_val;
   logic signed [WIDTH-1:0]   b_val;
   logic signed [2*WIDTH-1:0] prod;
   logic [WIDTH-1:0]          a_mag;
   logic [WIDTH-1:0]          b_mag;

   logic                    rsp_valid_ff;
   logic signed [WIDTH-1:0] rsp_result_ff;
   logic signed [WIDTH-1:0] rsp_result_in;
   logic                    rsp_zero_ff;
   logic                    rsp_lt_ff;
   logic                    rsp_eq_ff;
   logic                    rsp_gt_ff;
   logic [QUO_BITS-1:0]     quo;

   assign busy = reset;

   always_comb begin
      a_val = req_operand_a[WIDTH-1:0];
      b_val = req_operand_b[WIDTH-1:0];
      prod = (2*WIDTH)'(a_val) * (2*WIDTH)'(b_val);
      a_mag = a_val[WIDTH-1] ? WIDTH'(-a_val) : WIDTH'(a_val);
      b_mag = b_val[WIDTH-1] ? WIDTH'(-b_val) : WIDTH'(b_val);
      pipe_in[0].valid = start && !busy;
      pipe_in[0].op = op_type'(req_type);
      pipe_in[0].lt = a_val < b_val;
      pipe_in[0].eq = a_val == b_val;
      pipe_in[0].gt = a_val > b_val;
      pipe_in[0].zero_div = (op_type'(req_type) == OP_DIV) && (b_val == '0);
      pipe_in[0].neg = a_val[WIDTH-1] ^ b_val[WIDTH-1];
      pipe_in[0].rem = '0;
      pipe_in[0].dq = {a_mag, {FRAC_BITS{1'b0}}};
      pipe_in[0].dsr = b_mag;
      case (op_type'(req_type))
         OP_ADD: pipe_in[0].result = WIDTH'(a_val + b_val);
         OP_SUB: pipe_in[0].result = WIDTH'(a_val - b_val);
         OP_MUL: pipe_in[0].result = prod[FRAC_BITS+WIDTH-1:FRAC_BITS];
         OP_MIN: pipe_in[0].result = (a_val < b_val) ? a_val : b_val;
         OP_MAX: pipe_in[0].result = (a_val > b_val) ? a_val : b_val;
         default: pipe_in[0].result = '0;
      endcase
   end

   for (genvar i = 1; i <= QUO_BITS; i++) begin : g_div
      logic [WIDTH:0] trial;
      logic           take;
      always_comb begin
         trial = {pipe_ff[i-1].rem, pipe_ff[i-1].dq[QUO_BITS-1]};
         take = trial >= {1'b0, pipe_ff[i-1].dsr};
         pipe_in[i] = pipe_ff[i-1];
         pipe_in[i].rem = take ? WIDTH'(trial - {1'b0, pipe_ff[i-1].dsr})
                               : trial[WIDTH-1:0];
         pipe_in[i].dq = {pipe_ff[i-1].dq[QUO_BITS-2:0], take};
      end
   end

   for (genvar i = 0; i <= QUO_BITS; i++) begin : g_stage
      always_ff @(posedge clock) begin
         if (reset) begin
            pipe_ff[i].valid <= 1'b0;
         end else begin
            pipe_ff[i] <= pipe_in[i];
         end
      end
   end

   always_comb begin
      quo = pipe_ff[QUO_BITS].neg ? QUO_BITS'(-pipe_ff[QUO_BITS].dq)
                                  : pipe_ff[QUO_BITS].dq;
      if (pipe_ff[QUO_BITS].op == OP_DIV) begin
         rsp_result_in = pipe_ff[QUO_BITS].zero_div ? '0 : quo[WIDTH-1:0];
      end else begin
         rsp_result_in = pipe_ff[QUO_BITS].result;
      end
   end

   always_ff @(posedge clock) begin
      rsp_result_ff <= rsp_result_in;
      rsp_zero_ff <= pipe_ff[QUO_BITS].zero_div;
      rsp_lt_ff <= pipe_ff[QUO_BITS].lt;
      rsp_eq_ff <= pipe_ff[QUO_BITS].eq;
      rsp_gt_ff <= pipe_ff[QUO_BITS].gt;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= pipe_ff[QUO_BITS].valid;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_result_raw = PORT_BITS'(rsp_result_ff);
   assign rsp_div_by_zero = rsp_zero_ff;
   assign rsp_a_less = rsp_lt_ff;
   assign rsp_a_equal = rsp_eq_ff;
   assign rsp_a_greater = rsp_gt_ff;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid == $past(start && !busy, LATENCY))
      else $error("response strobe does not follow its request");

   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot({rsp_a_less, rsp_a_equal, rsp_a_greater}))
      else $error("comparison flags not exclusive");

   a_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_div_by_zero) |-> (rsp_result_raw == '0))
      else $error("division by zero gave a non-zero word");

endmodule

// ----- tb/sv/tb_fixed_point_alu_q24_8.sv -----
module tb_fixed_point_alu_q24_8
   import fpalu_pkg::*;
;

   typedef struct {
      logic signed [31:0] result_raw;
      logic               div_by_zero;
      logic               a_less;
      logic               a_equal;
      logic               a_greater;
   } alu_word_type;

   class alu_scoreboard;
      alu_word_type pending[$];
      int           checked = 0;
      int           mismatches = 0;

      task report_mismatch(input string what);
         mismatches++;
         $display("%0t mismatch: %s", $realtime, what);
      endtask

      function alu_word_type compute(input op_type op, input logic signed [31:0] a,
                                     input logic signed [31:0] b);
         alu_word_type       w;
         logic signed [63:0] wide;
         w.div_by_zero = 1'b0;
         w.a_less      = a < b;
         w.a_equal     = a == b;
         w.a_greater   = a > b;
         wide = 64'sd0;
         case (op)
            OP_ADD: wide = 64'(a) + 64'(b);
            OP_SUB: wide = 64'(a) - 64'(b);
            OP_MUL: wide = (64'(a) * 64'(b)) >>> FRAC_BITS;
            OP_DIV: begin
               if (b == 0) w.div_by_zero = 1'b1;
               else wide = (64'(a) <<< FRAC_BITS) / 64'(b);
            end
            OP_MIN: wide = (a < b) ? 64'(a) : 64'(b);
            OP_MAX: wide = (a > b) ? 64'(a) : 64'(b);
            default: wide = 64'sd0;
         endcase
         w.result_raw = wide[31:0];
         return w;
      endfunction

      function void note_request(input op_type op, input logic signed [31:0] a,
                                 input logic signed [31:0] b);
         pending.push_back(compute(op, a, b));
      endfunction

      task check_response(input alu_word_type got);
         alu_word_type exp;
         if (pending.size() == 0) begin
            report_mismatch("response with nothing expected");
         end else begin
            exp = pending.pop_front();
            checked++;
            if (got.result_raw !== exp.result_raw)
               report_mismatch($sformatf("result_raw %h, expected %h",
                                         got.result_raw, exp.result_raw));
            if (got.div_by_zero !== exp.div_by_zero)
               report_mismatch("div_by_zero");
            if (got.a_less !== exp.a_less) report_mismatch("a_less");
            if (got.a_equal !== exp.a_equal) report_mismatch("a_equal");
            if (got.a_greater !== exp.a_greater) report_mismatch("a_greater");
         end
      endtask
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [2:0]         req_type = '0;
   logic signed [31:0] req_operand_a = '0;
   logic signed [31:0] req_operand_b = '0;
   logic               rsp_valid;
   logic signed [31:0] rsp_result_raw;
   logic               rsp_div_by_zero, rsp_a_less, rsp_a_equal, rsp_a_greater;

   alu_scoreboard board = new();
   int            idle_cycles = 0;
   int            op_seen[8];

   always #4 clock = ~clock;

   fixed_point_alu_q24_8 uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_type(req_type), .req_operand_a(req_operand_a), .req_operand_b(req_operand_b),
      .rsp_valid(rsp_valid), .rsp_result_raw(rsp_result_raw),
      .rsp_div_by_zero(rsp_div_by_zero), .rsp_a_less(rsp_a_less),
      .rsp_a_equal(rsp_a_equal), .rsp_a_greater(rsp_a_greater)
   );

   always @(posedge clock) begin
      alu_word_type got;
      if (!reset) begin
         if (start && !busy) begin
            board.note_request(op_type'(req_type), req_operand_a, req_operand_b);
            op_seen[req_type]++;
         end
         if (rsp_valid) begin
            got.result_raw  = rsp_result_raw;
            got.div_by_zero = rsp_div_by_zero;
            got.a_less      = rsp_a_less;
            got.a_equal     = rsp_a_equal;
            got.a_greater   = rsp_a_greater;
            board.check_response(got);
         end
         if ((start && !busy) || rsp_valid) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles > 2000) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   task automatic send_word(input logic [2:0] op, input logic signed [31:0] a,
                            input logic signed [31:0] b);
      int gap;
      req_type      <= op;
      req_operand_a <= a;
      req_operand_b <= b;
      start         <= 1'b1;
      do @(posedge clock); while (busy);
      @(negedge clock);
      gap = ($urandom_range(0, 9) < 6) ? 0 :
            ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 60);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   function automatic logic signed [31:0] random_operand();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 3) == 0 ? 32'sd0 : 32'sh8000_0000;
         1: return $signed($urandom_range(0, 1024)) - 512;
         2: return $signed($urandom_range(0, 65536)) - 32768;
         3: return 32'sh7FFF_FFFF - $urandom_range(0, 3);
         default: return $signed($urandom());
      endcase
   endfunction

   initial begin
      logic signed [31:0] a, b;
      int                 ops;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      send_word(OP_ADD, 32'sh7FFF_FFFF, 32'sd1);
      send_word(OP_SUB, 32'sh8000_0000, 32'sd1);
      send_word(OP_MUL, 32'sh8000_0000, 32'sh8000_0000);
      send_word(OP_MUL, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
      send_word(OP_MUL, -32'sd1, 32'sd1);
      send_word(OP_MUL, 32'sd384, -32'sd640);
      send_word(OP_DIV, 32'sd256, 32'sd0);
      send_word(OP_DIV, 32'sh8000_0000, 32'sd0);
      send_word(OP_DIV, 32'sh8000_0000, -32'sd1);
      send_word(OP_DIV, -32'sd768, 32'sd512);
      send_word(OP_DIV, 32'sh7FFF_FFFF, 32'sd1);
      send_word(OP_DIV, 32'sd1, 32'sh8000_0000);
      send_word(OP_MIN, 32'sd5, 32'sd5);
      send_word(OP_MIN, -32'sd5, 32'sd5);
      send_word(OP_MAX, 32'sd7, 32'sd7);
      send_word(OP_MAX, 32'sh8000_0000, 32'sh7FFF_FFFF);
      send_word(OP_RSV6, 32'sd3, 32'sd2);
      send_word(OP_RSV7, -32'sd1, -32'sd1);
      send_word(OP_ADD, -32'sd1, -32'sd1);
      start <= 1'b0;
      while (board.pending.size() != 0) @(negedge clock);
      for (int i = 0; i < 450; i++) begin
         ops = $urandom_range(0, 19);
         a = random_operand();
         b = ($urandom_range(0, 7) == 0) ? a : random_operand();
         if ($urandom_range(0, 9) == 0) b = 32'sd0;
         send_word(ops < 18 ? 3'(ops % 6) : 3'(ops - 12), a, b);
         if (i == 200) begin
            start <= 1'b0;
            while (board.pending.size() != 0) @(negedge clock);
         end
      end
      start <= 1'b0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (LATENCY + 10) @(negedge clock);
      $display("Checked %0d responses; add %0d sub %0d mul %0d div %0d min %0d max %0d",
               board.checked, op_seen[OP_ADD], op_seen[OP_SUB], op_seen[OP_MUL],
               op_seen[OP_DIV], op_seen[OP_MIN], op_seen[OP_MAX]);
      $display("Unused codes sent: %0d, with operand extremes and zero divisors",
               op_seen[OP_RSV6] + op_seen[OP_RSV7]);
      if (board.mismatches == 0 && board.pending.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule
